// ----- src/qes_pkg.sv -----
// Shared types and constants for the quadrature encoder speed core.
// Used by the controller, the datapath and the top level.
package qes_pkg;

    localparam int unsigned SPEED_SCALE = 256000000;
    localparam int QUO_W       = 28;
    localparam int DIV_STEPS   = QUO_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int TIME_W      = 32;
    localparam int POS_W       = 16;
    localparam int SPEED_W     = 29;
    localparam int LIMIT_W     = 28;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 28;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 48;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 8'd3;

    localparam logic [MODE_W-1:0] MODE_X1 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_X2 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_X4 = 2'd2;

    localparam logic [LIMIT_W-1:0] MAX_SPEED_RESET = 28'hFFFFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SPEED,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic div_step;
        logic speed_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic act;
        logic d_zero;
        logic out_free;
    } stat_t;

endpackage

// ----- src/qes_ctrl.sv -----
// Sequencer for the encoder speed core: accept, divide, speed, emit.
// Depends on qes_pkg; drives qes_dp through cmd_t, reads stat_t.
module qes_ctrl
    import qes_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_tvalid,
    output logic   s_tready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    cnt_next = '0;
                    if (stat.act && !stat.d_zero) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SPEED;
                end
            end
            ST_SPEED: begin
                cmd.speed_load = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/qes_dp.sv -----
// Datapath: config registers, decoder, position, restoring divider, output register.
// Depends on qes_pkg; sequenced by qes_ctrl.
module qes_dp
    import qes_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    edge_on_b,
    input  logic                    level_a,
    input  logic                    level_b,
    input  logic [TIME_W-1:0]       now_us,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic                    counted,
    output logic signed [POS_W-1:0] position,
    output logic signed [SPEED_W-1:0] speed
);

    logic [MODE_W-1:0]          mode_reg;
    logic [LIMIT_W-1:0]         min_reg;
    logic [LIMIT_W-1:0]         max_reg;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [TIME_W-1:0]          time_reg;
    logic [SPEED_W-1:0]         speed_reg, speed_next;
    logic [TIME_W-1:0]          d_reg;
    logic [TIME_W-1:0]          rem_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic                       up_reg;
    logic                       act_reg;
    logic                       out_valid_reg;
    logic                       out_counted_reg;
    logic [POS_W-1:0]           out_pos_reg;
    logic [SPEED_W-1:0]         out_speed_reg;

    logic                       act;
    logic                       up;
    logic [TIME_W-1:0]          diff;
    logic [TIME_W:0]            trial;
    logic                       fits;
    logic                       cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Quadrature decode
    always_comb begin
        act = 1'b0;
        up  = 1'b0;
        if (!edge_on_b) begin
            if (mode_reg == MODE_X1) begin
                act = level_a;
                up  = !level_b;
            end else if (mode_reg == MODE_X2 || mode_reg == MODE_X4) begin
                act = 1'b1;
                up  = level_a ? !level_b : level_b;
            end
        end else if (mode_reg == MODE_X4) begin
            act = 1'b1;
            up  = level_a ? level_b : !level_b;
        end
    end

    assign diff          = now_us - time_reg;
    assign stat.act      = act;
    assign stat.d_zero   = (diff == '0);
    assign stat.out_free = !out_valid_reg || m_tready;

    assign pos_next = up ? pos_reg + 1'b1 : pos_reg - 1'b1;

    // One restoring step per cycle
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign fits  = (trial >= {1'b0, d_reg});

    always_comb begin
        if (quo_reg >= max_reg || quo_reg < min_reg) begin
            speed_next = '0;
        end else if (up_reg) begin
            speed_next = {1'b0, quo_reg};
        end else begin
            speed_next = SPEED_W'(0) - {1'b0, quo_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_X1;
            min_reg       <= '0;
            max_reg       <= MAX_SPEED_RESET;
            pos_reg       <= '0;
            time_reg      <= '0;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_COUNT_MODE:     mode_reg <= cfg_data[MODE_W-1:0];
                    REG_MIN_SPEED:      min_reg  <= cfg_data[LIMIT_W-1:0];
                    REG_MAX_SPEED:      max_reg  <= cfg_data[LIMIT_W-1:0];
                    REG_START_POSITION: pos_reg  <= cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.take && act) begin
                pos_reg  <= pos_next;
                time_reg <= now_us;
                if (diff == '0) begin
                    speed_reg <= '0;
                end
            end
            if (cmd.speed_load) begin
                speed_reg <= speed_next;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            up_reg  <= up;
            act_reg <= act;
            d_reg   <= diff;
            rem_reg <= '0;
            quo_reg <= QUO_W'(SPEED_SCALE);
        end else if (cmd.div_step) begin
            rem_reg <= fits ? TIME_W'(trial - {1'b0, d_reg}) : trial[TIME_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
        if (cmd.out_load) begin
            out_counted_reg <= act_reg;
            out_pos_reg     <= pos_reg;
            out_speed_reg   <= speed_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign counted  = out_counted_reg;
    assign position = out_pos_reg;
    assign speed    = out_speed_reg;

endmodule

// ----- src/quadrature_encoder_speed_core.sv -----
// Quadrature encoder position and speed core, x1/x2/x4 decoding.
// A counted event whose time difference is nonzero passes the accept state,
// 28 steps of the restoring divider (256e6 / delta_t), the speed state and the
// output load, which waits for a free output register. Ignored events and zero
// time differences go from accept straight to the output load. The 28-step
// divider sets the rate; a new beat is taken once the previous event has
// reached the output register, even if that beat is still waiting on m_tready.
// The config port is always ready; write it only while no event is in flight.
// Depends on qes_pkg, qes_ctrl and qes_dp.
module quadrature_encoder_speed_core
    import qes_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,   // level_a, level_b, now_us[31:0], zero pad
    input  logic                    s_tuser,   // edge_on_b
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,   // position[15:0], speed[28:0], zero pad
    output logic                    m_tuser,   // counted
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cmd_t                       cmd;
    stat_t                      stat;
    logic signed [POS_W-1:0]    position;
    logic signed [SPEED_W-1:0]  speed;

    qes_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qes_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .edge_on_b (s_tuser),
        .level_a   (s_tdata[0]),
        .level_b   (s_tdata[1]),
        .now_us    (s_tdata[TIME_W+1:2]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .counted   (m_tuser),
        .position  (position),
        .speed     (speed)
    );

    assign m_tdata = {{(M_TDATA_W - POS_W - SPEED_W){1'b0}}, speed, position};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an event is in flight");

    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result beat appeared without a finished event");

    a_single_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten while full");
`endif

endmodule

// ----- tb/quadrature_encoder_speed_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for quadrature_encoder_speed_core: quadrature walks, noise and
// directed corner events, with results predicted per beat and compared in order.
// Depends on qes_pkg and the core RTL.
module quadrature_encoder_speed_core_tb;
    import qes_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 8'hFF;
    localparam int                   STALL_CYCLES = 400;

    typedef struct packed {
        logic        edge_on_b;
        logic        level_a;
        logic        level_b;
        logic [31:0] now_us;
    } enc_event_t;

    typedef struct packed {
        logic                 counted;
        logic [POS_W-1:0]     position;
        logic [SPEED_W-1:0]   speed;
    } enc_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    quadrature_encoder_speed_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // shadow of the core's registers and state
    logic [MODE_W-1:0]  mode_r     = MODE_X1;
    logic [LIMIT_W-1:0] min_r      = '0;
    logic [LIMIT_W-1:0] max_r      = MAX_SPEED_RESET;
    logic [POS_W-1:0]   pos_r      = '0;
    logic [TIME_W-1:0]  last_t     = '0;
    logic [SPEED_W-1:0] last_spd   = '0;

    enc_event_t  edge_queue[$];
    enc_result_t predicted_results[$];
    enc_event_t  drive_ev;

    bit in_taken  = 1'b0;
    bit cfg_taken = 1'b0;
    int idle_pct  = 23;
    int stall_req = 0;
    int stall_seen = 0;
    int stall_left = 0;
    int errors    = 0;
    int n_events  = 0;
    int n_counted = 0;
    int n_checked = 0;
    int n_writes  = 0;

    // walk generator state
    logic        gen_a = 1'b0;
    logic        gen_b = 1'b0;
    logic        gen_fwd = 1'b1;
    logic [31:0] gen_time = '0;

    function automatic enc_result_t decode_event(enc_event_t ev);
        logic        act;
        logic        up;
        logic [31:0] dt;
        logic [31:0] q;
        enc_result_t r;
        act = 1'b0;
        up  = 1'b0;
        if (!ev.edge_on_b) begin
            if (mode_r == MODE_X1) begin
                if (ev.level_a) begin
                    act = 1'b1;
                    up  = !ev.level_b;
                end
            end else if (mode_r == MODE_X2 || mode_r == MODE_X4) begin
                act = 1'b1;
                up  = ev.level_a ? !ev.level_b : ev.level_b;
            end
        end else if (mode_r == MODE_X4) begin
            act = 1'b1;
            up  = ev.level_a ? ev.level_b : !ev.level_b;
        end
        if (act) begin
            dt     = ev.now_us - last_t;
            last_t = ev.now_us;
            pos_r  = up ? pos_r + 16'd1 : pos_r - 16'd1;
            q      = (dt == 0) ? 32'd0 : SPEED_SCALE / dt;
            if (dt == 0 || q >= {4'd0, max_r} || q < {4'd0, min_r})
                q = 32'd0;
            last_spd = up ? q[SPEED_W-1:0] : ({SPEED_W{1'b0}} - q[SPEED_W-1:0]);
        end
        r.counted  = act;
        r.position = pos_r;
        r.speed    = last_spd;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    task automatic push_event(logic on_b, logic a, logic b, logic [31:0] t);
        enc_event_t ev;
        ev = '{edge_on_b: on_b, level_a: a, level_b: b, now_us: t};
        edge_queue.push_back(ev);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
        n_writes++;
        case (idx)
            REG_COUNT_MODE:     mode_r = val[MODE_W-1:0];
            REG_MIN_SPEED:      min_r  = val[LIMIT_W-1:0];
            REG_MAX_SPEED:      max_r  = val[LIMIT_W-1:0];
            REG_START_POSITION: pos_r  = val[POS_W-1:0];
            default: ;
        endcase
    endtask

    // sender stays quiet until every predicted result has come back
    task automatic wait_idle();
        do @(negedge aclk);
        while (edge_queue.size() != 0 || s_tvalid || predicted_results.size() != 0);
    endtask

    task automatic queue_walk(int n);
        enc_event_t ev;
        logic [31:0] dt;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 15) begin
                ev.edge_on_b = 1'($urandom_range(1));
                ev.level_a   = 1'($urandom_range(1));
                ev.level_b   = 1'($urandom_range(1));
                ev.now_us    = $urandom;
            end else begin
                if ($urandom_range(9) == 0)
                    gen_fwd = !gen_fwd;
                ev.edge_on_b = gen_fwd ? (gen_a != gen_b) : (gen_a == gen_b);
                if (ev.edge_on_b)
                    gen_b = !gen_b;
                else
                    gen_a = !gen_a;
                case ($urandom_range(9))
                    0:          dt = 32'd0;
                    1, 2, 3, 4: dt = $urandom_range(50, 1);
                    5, 6, 7:    dt = $urandom_range(100000, 51);
                    8:          dt = $urandom_range(300000000, 100001);
                    default:    dt = $urandom;
                endcase
                gen_time   = gen_time + dt;
                ev.level_a = gen_a;
                ev.level_b = gen_b;
                ev.now_us  = gen_time;
            end
            edge_queue.push_back(ev);
        end
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (edge_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                drive_ev = edge_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'd0, drive_ev.now_us, drive_ev.level_b, drive_ev.level_a};
                s_tuser  <= drive_ev.edge_on_b;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_seen != stall_req) begin
                stall_seen = stall_req;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // monitor: predict on input beats, check on result beats
    always @(posedge aclk) begin
        enc_result_t want;
        in_taken  = aresetn && s_tvalid && s_tready;
        cfg_taken = aresetn && cfg_valid && cfg_ready;
        if (in_taken) begin
            want = decode_event(drive_ev);
            predicted_results.push_back(want);
            n_events++;
            if (want.counted)
                n_counted++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_results.size() == 0) begin
                report_mismatch("unexpected result beat", m_tdata[31:0], 32'd0);
            end else begin
                want = predicted_results.pop_front();
                n_checked++;
                if (m_tuser !== want.counted)
                    report_mismatch("counted", 32'(m_tuser), 32'(want.counted));
                if (m_tdata[15:0] !== want.position)
                    report_mismatch("position", 32'(m_tdata[15:0]), 32'(want.position));
                if (m_tdata[44:16] !== want.speed)
                    report_mismatch("speed", 32'(m_tdata[44:16]), 32'(want.speed));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [LIMIT_W-1:0] lo;
        logic [LIMIT_W-1:0] hi;
        logic [POS_W-1:0]   start;
        logic [MODE_W-1:0]  phase_mode[8];
        phase_mode = '{MODE_X4, MODE_X1, MODE_X2, MODE_X4,
                       MODE_UNUSED, MODE_X4, MODE_X2, MODE_X1};
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // x1: wrap of time, ignored falling A edge and B edge, zero delta
        push_event(1'b0, 1'b1, 1'b0, 32'd1);
        push_event(1'b0, 1'b1, 1'b1, 32'd1);
        push_event(1'b0, 1'b0, 1'b0, 32'd5);
        push_event(1'b1, 1'b1, 1'b1, 32'd9);
        push_event(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
        push_event(1'b0, 1'b1, 1'b0, 32'd3);
        wait_idle();

        // x2: position wraps in both directions
        write_reg(REG_START_POSITION, {12'd0, 16'h7FFF});
        write_reg(REG_COUNT_MODE, {26'd0, MODE_X2});
        push_event(1'b0, 1'b1, 1'b0, 32'd1003);
        push_event(1'b0, 1'b0, 1'b0, 32'd2003);
        push_event(1'b0, 1'b0, 1'b1, 32'd3003);
        push_event(1'b1, 1'b1, 1'b1, 32'd4003);
        wait_idle();

        // x4: speed at max, inside the window, below min
        write_reg(REG_START_POSITION, {12'd0, 16'h8000});
        write_reg(REG_COUNT_MODE, {26'd0, MODE_X4});
        write_reg(REG_MAX_SPEED, 28'd256000);
        write_reg(REG_MIN_SPEED, 28'd1000);
        push_event(1'b0, 1'b0, 1'b0, 32'd4003);
        push_event(1'b1, 1'b1, 1'b1, 32'd5004);
        push_event(1'b1, 1'b1, 1'b0, 32'd7004);
        push_event(1'b1, 1'b0, 1'b1, 32'd7005);
        push_event(1'b1, 1'b0, 1'b0, 32'd307005);
        push_event(1'b0, 1'b1, 1'b1, 32'd307006);
        wait_idle();

        // reserved mode and an unmapped register index
        write_reg(REG_COUNT_MODE, {26'd0, MODE_UNUSED});
        write_reg(REG_UNUSED, 28'hFFFFFFF);
        push_event(1'b0, 1'b1, 1'b0, 32'd400000);
        push_event(1'b1, 1'b0, 1'b1, 32'd400001);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            if (p == 1) begin
                lo = '0;
                hi = '0;
            end else if (p == 2) begin
                lo = 28'hFFFFFFF;
                hi = 28'hFFFFFFF;
            end else if (p % 2 == 1) begin
                lo = LIMIT_W'($urandom_range(5000));
                hi = LIMIT_W'($urandom_range(268435455, 100000));
            end else begin
                lo = '0;
                hi = 28'hFFFFFFF;
            end
            if (p == 3)
                start = 16'h7FFF;
            else if (p == 6)
                start = 16'h8000;
            else
                start = POS_W'($urandom);
            idle_pct = (p == 3) ? 0 : 23;
            write_reg(REG_COUNT_MODE, {26'd0, phase_mode[p]});
            write_reg(REG_MIN_SPEED, lo);
            write_reg(REG_MAX_SPEED, hi);
            write_reg(REG_START_POSITION, {12'd0, start});
            queue_walk(phase_mode[p] == MODE_UNUSED ? 30 : 110);
            if (p == 5)
                stall_req++;
            wait_idle();
        end

        repeat (40) @(posedge aclk);
        $display("Covered %0d encoder events, %0d of them counted, %0d results checked,",
                 n_events, n_counted, n_checked);
        $display("across %0d register writes in all count modes and speed windows.",
                 n_writes);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
src/qes_pkg.sv
src/qes_ctrl.sv
src/qes_dp.sv
src/quadrature_encoder_speed_core.sv
tb/quadrature_encoder_speed_core_tb.sv
